// ----- rtl/core/i2af_pkg.sv -----
package i2af_pkg;

  // Request kinds carried on in_tuser
  localparam logic [1:0] REQ_HEX  = 2'd0;
  localparam logic [1:0] REQ_UDEC = 2'd1;
  localparam logic [1:0] REQ_SDEC = 2'd2;

  // Input tdata layout: value, hex_bytes, upper_case, zero pad to 40 bits
  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 2;
  localparam int VAL_W      = 32;
  localparam int VAL_LSB    = 0;
  localparam int NBYTES_LSB = 32;
  localparam int NBYTES_W   = 3;
  localparam int UPPER_BIT  = 35;

  // Output tdata layout: ascii_char, zero pad to 8 bits
  localparam int OUT_DATA_W = 8;
  localparam int CHAR_W     = 7;

  // Digit count fits 20 decimal digits of a 64-bit value
  localparam int CNT_W = 5;

  // Character codes and offsets
  localparam logic [CHAR_W-1:0] CH_ZERO   = 7'd48;
  localparam logic [CHAR_W-1:0] CH_X      = 7'd120;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 7'd45;
  localparam logic [CHAR_W-1:0] OFS_UPPER = 7'd55;
  localparam logic [CHAR_W-1:0] OFS_LOWER = 7'd87;
  localparam logic [3:0]        DEC_BASE  = 4'd10;
  localparam logic [3:0]        DD_LIMIT  = 4'd5;
  localparam logic [3:0]        DD_ADJ    = 4'd3;

  // Per-number control handed from front to back
  typedef struct packed {
    logic             hex;
    logic             upper;
    logic             neg;
    logic [CNT_W-1:0] ndig;
  } fmt_ctl_t;

  // Digit slots needed: decimal digits of 2^vb-1 or hex digits, whichever is more
  function automatic int nd_all(input int vb);
    int ndec;
    int nhex;
    ndec = (vb * 1233) / 4096 + 1;
    nhex = 2 * ((vb + 7) / 8);
    return (ndec > nhex) ? ndec : nhex;
  endfunction

  // Map one digit to its ASCII code
  function automatic logic [CHAR_W-1:0] dig2char(input logic [3:0] nib, input logic upper);
    logic [CHAR_W-1:0] ext;
    ext = {3'b000, nib};
    if (nib < DEC_BASE) return ext + CH_ZERO;
    return ext + (upper ? OFS_UPPER : OFS_LOWER);
  endfunction

endpackage

// ----- rtl/core/i2af_queue.sv -----
module i2af_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_wr ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_rd ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entry
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- rtl/core/i2af_front.sv -----
module i2af_front #(
  parameter int VALUE_BITS = 32
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  input  logic [i2af_pkg::IN_DATA_W-1:0]             in_tdata,
  input  logic [i2af_pkg::IN_USER_W-1:0]             in_tuser,
  output logic                                       push_valid,
  input  logic                                       push_ready,
  output i2af_pkg::fmt_ctl_t                         push_ctl,
  output logic [i2af_pkg::nd_all(VALUE_BITS)*4-1:0]  push_dig
);

  import i2af_pkg::*;

  localparam int VB     = VALUE_BITS;
  localparam int MAG_W  = ((VB + 1) / 2) * 2;
  localparam int STEPS  = MAG_W / 2;
  localparam int STEP_W = $clog2(STEPS);
  localparam int ND     = nd_all(VB);
  localparam int DIG_W  = ND * 4;
  localparam int MAXB   = (VB + 7) / 8;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_CONV = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]        state_r, state_nxt;
  fmt_ctl_t          ctl_r, ctl_nxt;
  logic [DIG_W-1:0]  dig_r, dig_nxt;
  logic [MAG_W-1:0]  mag_r, mag_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  logic              accept;
  logic [1:0]        req;
  logic [VB-1:0]     in_v;
  logic              neg_in;
  logic [VB-1:0]     mag_in;
  logic [3:0]        nb4;
  logic [3:0]        nb_clamp;
  logic [DIG_W-1:0]  dd;
  logic [CNT_W-1:0]  cnt_dec;

  assign accept = in_tvalid && in_tready;
  assign req    = in_tuser;
  assign in_v   = VB'(in_tdata[VAL_LSB +: VAL_W]);
  assign neg_in = (req == REQ_SDEC) && in_v[VB-1];
  assign mag_in = neg_in ? (~in_v + VB'(1)) : in_v;
  assign nb4    = {1'b0, in_tdata[NBYTES_LSB +: NBYTES_W]};

  // Clamp hex byte count to one .. bytes of the value
  always_comb begin
    nb_clamp = nb4;
    if (nb4 == 4'd0) nb_clamp = 4'd1;
    else if (nb4 > 4'(MAXB)) nb_clamp = 4'(MAXB);
  end

  // Two double-dabble steps: adjust each BCD digit, then shift in a magnitude bit
  always_comb begin
    dd = dig_r;
    for (int s = 0; s < 2; s++) begin
      for (int k = 0; k < ND; k++) begin
        if (dd[k*4 +: 4] >= DD_LIMIT) dd[k*4 +: 4] = dd[k*4 +: 4] + DD_ADJ;
      end
      dd = {dd[DIG_W-2:0], mag_r[MAG_W-1-s]};
    end
  end

  // Count significant decimal digits; zero still shows one digit
  always_comb begin
    cnt_dec = CNT_W'(1);
    for (int k = 0; k < ND; k++) begin
      if (dig_r[k*4 +: 4] != 4'd0) cnt_dec = CNT_W'(k + 1);
    end
  end

  // Sequence accept, conversion and hand-off
  always_comb begin
    state_nxt = state_r;
    ctl_nxt   = ctl_r;
    dig_nxt   = dig_r;
    mag_nxt   = mag_r;
    step_nxt  = step_r;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          case (req)
            REQ_HEX: begin
              ctl_nxt.hex   = 1'b1;
              ctl_nxt.upper = in_tdata[UPPER_BIT];
              ctl_nxt.neg   = 1'b0;
              ctl_nxt.ndig  = CNT_W'({nb_clamp, 1'b0});
              dig_nxt       = DIG_W'(in_v);
              state_nxt     = F_PUSH;
            end
            REQ_UDEC, REQ_SDEC: begin
              ctl_nxt.hex   = 1'b0;
              ctl_nxt.upper = 1'b0;
              ctl_nxt.neg   = neg_in;
              ctl_nxt.ndig  = '0;
              dig_nxt       = '0;
              mag_nxt       = MAG_W'(mag_in);
              step_nxt      = STEP_W'(STEPS - 1);
              state_nxt     = F_CONV;
            end
            default: begin
              // drop the unused request kind
              state_nxt = F_IDLE;
            end
          endcase
        end
      end
      F_CONV: begin
        dig_nxt  = dd;
        mag_nxt  = mag_r << 2;
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (push_ready) state_nxt = F_IDLE;
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  assign in_tready  = (state_r == F_IDLE);
  assign push_valid = (state_r == F_PUSH);
  assign push_dig   = dig_r;

  always_comb begin
    push_ctl = ctl_r;
    if (!ctl_r.hex) push_ctl.ndig = cnt_dec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctl_r  <= ctl_nxt;
    dig_r  <= dig_nxt;
    mag_r  <= mag_nxt;
    step_r <= step_nxt;
  end

endmodule

// ----- rtl/core/i2af_back.sv -----
module i2af_back #(
  parameter int VALUE_BITS = 32
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       pop_valid,
  output logic                                       pop_ready,
  input  i2af_pkg::fmt_ctl_t                         pop_ctl,
  input  logic [i2af_pkg::nd_all(VALUE_BITS)*4-1:0]  pop_dig,
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  output logic [i2af_pkg::OUT_DATA_W-1:0]            out_tdata,
  output logic                                       out_tlast
);

  import i2af_pkg::*;

  localparam int ND    = nd_all(VALUE_BITS);
  localparam int IDX_W = $clog2(ND);

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_PFX0  = 2'd1;
  localparam logic [1:0] B_PFX1  = 2'd2;
  localparam logic [1:0] B_DIGIT = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic                  hex_r, hex_nxt;
  logic                  upper_r, upper_nxt;
  logic [ND-1:0][3:0]    dig_r, dig_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]     out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  slot;
  logic                  emit;
  logic [CNT_W-1:0]      ndig_m1;

  assign slot      = !out_valid_r || out_tready;
  assign pop_ready = (state_r == B_IDLE);
  assign ndig_m1   = pop_ctl.ndig - CNT_W'(1);

  // Walk prefix then digits, one character per free output slot
  always_comb begin
    state_nxt    = state_r;
    hex_nxt      = hex_r;
    upper_nxt    = upper_r;
    dig_nxt      = dig_r;
    idx_nxt      = idx_r;
    emit         = 1'b0;
    out_char_nxt = out_char_r;
    out_last_nxt = out_last_r;
    case (state_r)
      B_IDLE: begin
        if (pop_valid) begin
          hex_nxt   = pop_ctl.hex;
          upper_nxt = pop_ctl.upper;
          dig_nxt   = pop_dig;
          idx_nxt   = IDX_W'(ndig_m1);
          state_nxt = (pop_ctl.hex || pop_ctl.neg) ? B_PFX0 : B_DIGIT;
        end
      end
      B_PFX0: begin
        if (slot) begin
          emit         = 1'b1;
          out_char_nxt = hex_r ? CH_ZERO : CH_MINUS;
          out_last_nxt = 1'b0;
          state_nxt    = hex_r ? B_PFX1 : B_DIGIT;
        end
      end
      B_PFX1: begin
        if (slot) begin
          emit         = 1'b1;
          out_char_nxt = CH_X;
          out_last_nxt = 1'b0;
          state_nxt    = B_DIGIT;
        end
      end
      B_DIGIT: begin
        if (slot) begin
          emit         = 1'b1;
          out_char_nxt = dig2char(dig_r[idx_r], upper_r);
          out_last_nxt = (idx_r == '0);
          if (idx_r == '0) state_nxt = B_IDLE;
          else idx_nxt = idx_r - IDX_W'(1);
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  // Hold the output register until it is taken
  always_comb begin
    if (emit) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_char_r};
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hex_r      <= hex_nxt;
    upper_r    <= upper_nxt;
    dig_r      <= dig_nxt;
    idx_r      <= idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

// ----- rtl/core/integer_to_ascii_formatter_core.sv -----
// Formats a number as ASCII text, one character per output transfer, most
// significant first, with out_tlast on the final character: hex as "0x" plus
// two digits per requested byte (clamped to one up to the bytes of the value),
// or decimal without leading zeros, with '-' for negative values in signed
// mode. A front end takes the request and, for decimal, converts the magnitude
// to BCD two bits per cycle; a two-entry queue passes the digits to a back end
// that sends one character per cycle while out_tready does not stall it. A hex
// request goes from idle straight to the hand-off to the queue; a decimal
// request first passes through the BCD conversion state. The back end loads an
// entry, then sends its characters (at most 11 at 32 bits); the two ends
// overlap, so the front end can take a new request while the back end still
// sends the last one. Request kind 3 produces no output.
module integer_to_ascii_formatter_core #(
  parameter int VALUE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [31:0] value, [34:32] hex_bytes, [35] upper_case, [39:36] zero
  input  logic [i2af_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] req_type
  input  logic [i2af_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [6:0] ascii_char, [7] zero
  output logic [i2af_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast
);

  import i2af_pkg::*;

  localparam int DIG_W = nd_all(VALUE_BITS) * 4;
  localparam int CTL_W = $bits(fmt_ctl_t);
  localparam int Q_W   = CTL_W + DIG_W;

  logic             push_valid, push_ready;
  fmt_ctl_t         push_ctl;
  logic [DIG_W-1:0] push_dig;
  logic             pop_valid, pop_ready;
  logic [Q_W-1:0]   pop_data;
  fmt_ctl_t         pop_ctl;
  logic [DIG_W-1:0] pop_dig;

  assign pop_ctl = fmt_ctl_t'(pop_data[Q_W-1 -: CTL_W]);
  assign pop_dig = pop_data[DIG_W-1:0];

  i2af_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_ctl   (push_ctl),
    .push_dig   (push_dig)
  );

  i2af_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  ({push_ctl, push_dig}),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (pop_data)
  );

  i2af_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_ctl    (pop_ctl),
    .pop_dig    (pop_dig),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- rtl/core/i2af_checker.sv -----
module i2af_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [i2af_pkg::IN_USER_W-1:0]  in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [i2af_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tlast
);

  import i2af_pkg::*;

  // Stalled output transfer holds its character and marker
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // A real request keeps the front end busy for the next cycle
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == REQ_HEX || in_tuser == REQ_UDEC ||
    in_tuser == REQ_SDEC) |=> !in_tready)
    else $error("front end took a request while converting");

  // Every character lies between '-' and 'x'
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata >= {1'b0, CH_MINUS} && out_tdata <= {1'b0, CH_X})
    else $error("character out of range");

endmodule

bind integer_to_ascii_formatter_core i2af_checker u_i2af_checker (.*);

// ----- bench/tb_integer_to_ascii_formatter_core.sv -----
module tb_integer_to_ascii_formatter_core;
  timeunit 1ns;
  timeprecision 1ps;

  import i2af_pkg::*;

  // Request kind with no output
  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int RANDOM_REQUESTS = 306;
  localparam int TAIL_REQUESTS   = 40;
  localparam int SETTLE_CYCLES   = 64;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] value;
    logic [2:0]  nbytes;
    logic        upper;
    bit          drain;
    bit          tail;
  } fmt_request_t;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  fmt_request_t pending_requests[$];
  text_char_t   expected_chars[$];
  logic         in_took = 1'b0;
  logic         quiet_tail = 1'b0;
  int           fail_count = 0;

  integer_to_ascii_formatter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #2 clk = ~clk;

  function automatic void push_char(input logic [7:0] ch);
    text_char_t c;
    c.code = ch[CHAR_W-1:0];
    c.last = 1'b0;
    expected_chars.push_back(c);
  endfunction

  // Append the characters one request should produce
  function automatic void format_number(input logic [1:0] kind, input logic [31:0] value,
                                        input logic [2:0] nbytes, input logic upper);
    int          ndig;
    int          count;
    int          base;
    logic [3:0]  nib;
    logic [3:0]  digs[10];
    logic [32:0] mag;
    logic [32:0] rem;
    logic        neg;
    base = expected_chars.size();
    case (kind)
      REQ_HEX: begin
        ndig = (nbytes == 3'd0) ? 2 : (nbytes > 3'd4) ? 8 : 2 * nbytes;
        push_char("0");
        push_char("x");
        for (int k = ndig - 1; k >= 0; k--) begin
          nib = value[k*4 +: 4];
          if (nib < 4'd10) push_char("0" + {4'h0, nib});
          else if (upper) push_char("A" + {4'h0, nib} - 8'd10);
          else push_char("a" + {4'h0, nib} - 8'd10);
        end
      end
      REQ_UDEC, REQ_SDEC: begin
        neg = (kind == REQ_SDEC) && value[31];
        // two's complement magnitude, wide enough for the most negative value
        mag = neg ? (33'h1_0000_0000 - {1'b0, value}) : {1'b0, value};
        count = 0;
        do begin
          rem = mag % 33'd10;
          digs[count] = rem[3:0];
          mag = mag / 33'd10;
          count++;
        end while (mag != 33'd0);
        if (neg) push_char("-");
        for (int k = count - 1; k >= 0; k--) push_char("0" + {4'h0, digs[k]});
      end
      default: ;
    endcase
    if (expected_chars.size() > base) expected_chars[expected_chars.size() - 1].last = 1'b1;
  endfunction

  function automatic void add_request(input logic [1:0] kind, input logic [31:0] value,
                                      input logic [2:0] nbytes, input logic upper,
                                      input bit drain);
    fmt_request_t r;
    r.kind   = kind;
    r.value  = value;
    r.nbytes = nbytes;
    r.upper  = upper;
    r.drain  = drain;
    r.tail   = 1'b0;
    pending_requests.push_back(r);
  endfunction

  // Request driver: present queued requests with random gaps between them
  always @(negedge clk) begin : drive_requests
    fmt_request_t         req;
    logic [IN_DATA_W-1:0] word;
    int                   gap_left;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left = 0;
    end else if (!in_tvalid || in_took) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_requests.size() != 0 &&
                   !(pending_requests[0].drain && expected_chars.size() != 0)) begin
        req = pending_requests.pop_front();
        word = '0;
        word[VAL_LSB +: VAL_W]       = req.value;
        word[NBYTES_LSB +: NBYTES_W] = req.nbytes;
        word[UPPER_BIT]              = req.upper;
        in_tdata  <= word;
        in_tuser  <= req.kind;
        in_tvalid <= 1'b1;
        if (req.tail) quiet_tail <= 1'b1;
        else if ($urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 7);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: stall in random bursts, none in the tail
  always @(negedge clk) begin : drive_ready
    int stall_left;
    int stall_pct;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
      stall_pct = 20;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_pct = $urandom_range(0, 2) * 20;
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 6);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor: check each output transfer, predict on each input transfer
  always @(posedge clk) begin : watch_ports
    text_char_t want;
    in_took <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character 0x%02h last %0b", out_tdata, out_tlast);
          fail_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_tdata[CHAR_W-1:0] !== want.code) begin
            $error("ascii_char: expected 0x%02h, got 0x%02h", want.code,
                   out_tdata[CHAR_W-1:0]);
            fail_count++;
          end
          if (out_tlast !== want.last) begin
            $error("last_char: expected %0b, got %0b", want.last, out_tlast);
            fail_count++;
          end
          if (out_tdata[OUT_DATA_W-1:CHAR_W] !== '0) begin
            $error("tdata pad: expected 0, got %0b", out_tdata[OUT_DATA_W-1:CHAR_W]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        format_number(in_tuser, in_tdata[VAL_LSB +: VAL_W],
                      in_tdata[NBYTES_LSB +: NBYTES_W], in_tdata[UPPER_BIT]);
    end
  end

  initial begin : run_sequence
    fmt_request_t r;
    int           produced;
    int           width;
    logic [31:0]  mask;
    // extremes of hex width, case and value
    add_request(REQ_HEX, 32'h0000_0000, 3'd4, 1'b0, 1'b0);
    add_request(REQ_HEX, 32'hFFFF_FFFF, 3'd4, 1'b1, 1'b0);
    add_request(REQ_HEX, 32'hFFFF_FFFF, 3'd4, 1'b0, 1'b0);
    add_request(REQ_HEX, 32'h89AB_CDEF, 3'd0, 1'b1, 1'b0);
    add_request(REQ_HEX, 32'h1234_5678, 3'd7, 1'b0, 1'b0);
    add_request(REQ_HEX, 32'h0000_00A5, 3'd1, 1'b1, 1'b0);
    add_request(REQ_HEX, 32'hDEAD_BEEF, 3'd2, 1'b0, 1'b0);
    add_request(REQ_HEX, 32'h0123_4567, 3'd3, 1'b1, 1'b0);
    // unsigned decimal, hex fields ignored
    add_request(REQ_UDEC, 32'h0000_0000, 3'd0, 1'b0, 1'b0);
    add_request(REQ_UDEC, 32'hFFFF_FFFF, 3'd5, 1'b1, 1'b0);
    add_request(REQ_UDEC, 32'd1, 3'd2, 1'b0, 1'b0);
    add_request(REQ_UDEC, 32'd9, 3'd7, 1'b1, 1'b0);
    add_request(REQ_UDEC, 32'd10, 3'd1, 1'b0, 1'b0);
    add_request(REQ_UDEC, 32'd999999999, 3'd4, 1'b0, 1'b0);
    add_request(REQ_UDEC, 32'd1000000000, 3'd4, 1'b1, 1'b0);
    // signed decimal: zero without sign, most negative, boundaries
    add_request(REQ_SDEC, 32'h0000_0000, 3'd7, 1'b1, 1'b0);
    add_request(REQ_SDEC, 32'h8000_0000, 3'd0, 1'b0, 1'b0);
    add_request(REQ_SDEC, 32'h7FFF_FFFF, 3'd4, 1'b0, 1'b0);
    add_request(REQ_SDEC, 32'hFFFF_FFFF, 3'd4, 1'b1, 1'b0);
    add_request(REQ_SDEC, 32'hFFFF_FFF6, 3'd3, 1'b0, 1'b0);
    add_request(REQ_SDEC, 32'd5, 3'd1, 1'b0, 1'b0);
    // unused kind twice, then a hex request once all expected output has drained
    add_request(REQ_NONE, 32'hFFFF_FFFF, 3'd7, 1'b1, 1'b0);
    add_request(REQ_NONE, 32'h0000_0000, 3'd0, 1'b0, 1'b0);
    add_request(REQ_HEX, 32'h5A5A_5A5A, 3'd6, 1'b1, 1'b1);

    produced = 0;
    while (produced < RANDOM_REQUESTS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: r.kind = REQ_HEX;
        3, 4, 5: r.kind = REQ_UDEC;
        6, 7, 8: r.kind = REQ_SDEC;
        default: r.kind = REQ_NONE;
      endcase
      width = $urandom_range(1, 32);
      mask = 32'hFFFF_FFFF >> (32 - width);
      case ($urandom_range(0, 3))
        0: r.value = $urandom;
        1: r.value = $urandom & mask;
        2: r.value = -($urandom & mask);
        default: begin
          case ($urandom_range(0, 5))
            0: r.value = 32'h0000_0000;
            1: r.value = 32'h8000_0000;
            2: r.value = 32'h7FFF_FFFF;
            3: r.value = 32'hFFFF_FFFF;
            4: r.value = 32'd999999999;
            default: r.value = 32'd1000000000;
          endcase
        end
      endcase
      r.nbytes = $urandom_range(0, 7);
      r.upper  = $urandom_range(0, 1);
      r.drain  = (produced == RANDOM_REQUESTS / 2);
      r.tail   = produced >= RANDOM_REQUESTS - TAIL_REQUESTS;
      pending_requests.push_back(r);
      produced++;
    end

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // wait for the last transfer and its characters, then let the block settle
    while (pending_requests.size() != 0 || in_tvalid || expected_chars.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("tb_integer_to_ascii_formatter_core OK");
    else $display("tb_integer_to_ascii_formatter_core NOT OK");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("tb_integer_to_ascii_formatter_core NOT OK");
    $finish;
  end

endmodule
